// File: rtl/video_raster_timing_sync_status_defines.svh
// Assertion macros shared by the raster timing block.
`ifndef VIDEO_RASTER_TIMING_SYNC_STATUS_DEFINES_SVH
`define VIDEO_RASTER_TIMING_SYNC_STATUS_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define VRTS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("vrts: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define VRTS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("vrts: next-cycle check failed");

`endif

// File: rtl/vrts_pkg.sv
package vrts_pkg;

    localparam int LINE_BITS = 10;
    localparam int TIME_BITS = 16;
    // time left in a line plus one advance needs one extra bit
    localparam int REM_BITS  = TIME_BITS + 1;

    localparam int ADV_W     = 16;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 48;
    localparam int SCAN_W    = 10;
    localparam int FRAME_W   = 32;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    // register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_FRAME_LINES  = 3'd0;
    localparam logic [2:0] REG_LINE_TIME    = 3'd1;
    localparam logic [2:0] REG_INTERLACE_ON = 3'd2;
    localparam logic [2:0] REG_VSYNC_LINES  = 3'd3;
    localparam logic [2:0] REG_HSYNC_WIDTH  = 3'd4;
    localparam logic [2:0] REG_FRONT_PORCH  = 3'd5;
    localparam logic [2:0] REG_BACK_PORCH   = 3'd6;
    localparam logic [2:0] REG_RETRACE_END  = 3'd7;

    localparam logic [10:0] RST_FRAME_LINES = 11'd625;
    localparam logic [15:0] RST_LINE_TIME   = 16'd32000;
    localparam logic        RST_INTERLACE   = 1'b0;
    localparam logic [3:0]  RST_VSYNC_LINES = 4'd5;
    localparam logic [15:0] RST_HSYNC_WIDTH = 16'd4740;
    localparam logic [15:0] RST_FRONT_PORCH = 16'd0;
    localparam logic [15:0] RST_BACK_PORCH  = 16'd4000;
    localparam logic [9:0]  RST_RETRACE_END = 10'd42;

    typedef struct packed {
        logic [10:0] frame_lines;
        logic [15:0] line_time;
        logic        interlace_on;
        logic [3:0]  vsync_line_count;
        logic [15:0] hsync_width;
        logic [15:0] front_porch;
        logic [15:0] back_porch;
        logic [9:0]  retrace_end;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic step;
        logic capture;
    } cmd_t;

    typedef struct packed {
        logic need_step;
    } sts_t;

endpackage

// File: rtl/vrts_regs.sv
module vrts_regs
    import vrts_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [2:0] reg_index;
    logic       wr_en;

    assign pready    = 1'b1;
    assign reg_index = paddr[4:2];
    assign wr_en     = psel && penable && pwrite && pready;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_index)
                REG_FRAME_LINES:  cfg_next.frame_lines      = pwdata[10:0];
                REG_LINE_TIME:    cfg_next.line_time        = pwdata[15:0];
                REG_INTERLACE_ON: cfg_next.interlace_on     = pwdata[0];
                REG_VSYNC_LINES:  cfg_next.vsync_line_count = pwdata[3:0];
                REG_HSYNC_WIDTH:  cfg_next.hsync_width      = pwdata[15:0];
                REG_FRONT_PORCH:  cfg_next.front_porch      = pwdata[15:0];
                REG_BACK_PORCH:   cfg_next.back_porch       = pwdata[15:0];
                REG_RETRACE_END:  cfg_next.retrace_end      = pwdata[9:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_lines      <= RST_FRAME_LINES;
            cfg_reg.line_time        <= RST_LINE_TIME;
            cfg_reg.interlace_on     <= RST_INTERLACE;
            cfg_reg.vsync_line_count <= RST_VSYNC_LINES;
            cfg_reg.hsync_width      <= RST_HSYNC_WIDTH;
            cfg_reg.front_porch      <= RST_FRONT_PORCH;
            cfg_reg.back_porch       <= RST_BACK_PORCH;
            cfg_reg.retrace_end      <= RST_RETRACE_END;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        case (reg_index)
            REG_FRAME_LINES:  prdata = 32'(cfg_reg.frame_lines);
            REG_LINE_TIME:    prdata = 32'(cfg_reg.line_time);
            REG_INTERLACE_ON: prdata = 32'(cfg_reg.interlace_on);
            REG_VSYNC_LINES:  prdata = 32'(cfg_reg.vsync_line_count);
            REG_HSYNC_WIDTH:  prdata = 32'(cfg_reg.hsync_width);
            REG_FRONT_PORCH:  prdata = 32'(cfg_reg.front_porch);
            REG_BACK_PORCH:   prdata = 32'(cfg_reg.back_porch);
            REG_RETRACE_END:  prdata = 32'(cfg_reg.retrace_end);
            default:          prdata = '0;
        endcase
    end

endmodule

// File: rtl/vrts_datapath.sv
module vrts_datapath
    import vrts_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  cfg_t                   cfg,
    input  cmd_t                   cmd,
    input  logic [ADV_W-1:0]       advance_ns,
    output sts_t                   sts,
    output logic [OUT_TDATA_W-1:0] out_data
);

    logic [LINE_BITS-1:0] line_reg, line_next;
    logic [REM_BITS-1:0]  time_reg, time_next;
    logic                 field_reg, field_next;
    logic [FRAME_W-1:0]   frame_reg, frame_next;
    logic                 started_reg, started_next;
    logic [OUT_TDATA_W-1:0] out_data_reg;

    logic                 timing_on;
    logic [REM_BITS-1:0]  line_time_x;
    logic [LINE_BITS-1:0] line_inc;
    logic                 wrap;
    logic [LINE_BITS-1:0] line_stepped;
    logic                 hit_retrace;

    logic                 parity_match;
    logic                 past_vsync;
    logic [TIME_BITS-1:0] active_limit;
    logic                 hs_off, vs_off, active;

    assign timing_on   = cfg.line_time != '0;
    assign line_time_x = REM_BITS'(cfg.line_time);
    assign sts.need_step = timing_on && (time_reg >= line_time_x);

    assign line_inc     = line_reg + LINE_BITS'(1);
    assign wrap         = (line_inc == '0) || (32'(line_inc) >= 32'(cfg.frame_lines));
    assign line_stepped = wrap ? '0 : line_inc;
    assign hit_retrace  = 32'(line_stepped) == 32'(cfg.retrace_end);

    always_comb begin
        line_next    = line_reg;
        time_next    = time_reg;
        field_next   = field_reg;
        frame_next   = frame_reg;
        started_next = started_reg;
        if (cmd.load) begin
            started_next = 1'b0;
            // frozen timing ignores the advance
            if (timing_on) begin
                time_next = time_reg + REM_BITS'(advance_ns);
            end
        end else if (cmd.step) begin
            time_next = time_reg - line_time_x;
            line_next = line_stepped;
            if (wrap && cfg.interlace_on) begin
                field_next = ~field_reg;
            end
            if (hit_retrace) begin
                frame_next   = frame_reg + FRAME_W'(1);
                started_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_reg    <= '0;
            time_reg    <= '0;
            field_reg   <= 1'b0;
            frame_reg   <= '0;
            started_reg <= 1'b0;
        end else begin
            line_reg    <= line_next;
            time_reg    <= time_next;
            field_reg   <= field_next;
            frame_reg   <= frame_next;
            started_reg <= started_next;
        end
    end

    // sync decode from the settled state
    assign parity_match = line_reg[0] == field_reg;
    assign past_vsync   = 32'(line_reg) >= 32'(cfg.vsync_line_count);
    assign active_limit = (cfg.line_time > cfg.back_porch) ?
                          (cfg.line_time - cfg.back_porch) : '0;

    always_comb begin
        if (parity_match) begin
            hs_off = time_reg > REM_BITS'(cfg.hsync_width);
            active = past_vsync && (time_reg > REM_BITS'(cfg.front_porch));
        end else begin
            hs_off = 1'b1;
            active = past_vsync && (time_reg < REM_BITS'(active_limit));
        end
        vs_off = past_vsync;
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            out_data_reg <= {1'b0, frame_reg, started_reg, vs_off, hs_off, active,
                             field_reg, SCAN_W'(line_reg)};
        end
    end

    assign out_data = out_data_reg;

endmodule

// File: rtl/vrts_ctrl.sv
`include "video_raster_timing_sync_status_defines.svh"

module vrts_ctrl
    import vrts_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    output logic m_tvalid,
    input  logic m_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   out_free;

    assign s_tready = state_reg == S_IDLE;
    assign m_tvalid = m_tvalid_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next  = state_reg;
        cmd.load    = 1'b0;
        cmd.step    = 1'b0;
        cmd.capture = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_RUN;
                end
            end
            S_RUN: begin
                // take whole lines off first, then hand over once the output is free
                if (sts.need_step) begin
                    cmd.step = 1'b1;
                end else if (out_free) begin
                    cmd.capture = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.capture) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    `VRTS_ASSERT_IMP(a_capture_free, aclk, aresetn, cmd.capture, !m_tvalid_reg || m_tready)
    `VRTS_ASSERT_NXT(a_accept_runs, aclk, aresetn, s_tvalid && s_tready, state_reg == S_RUN)
    `VRTS_ASSERT_IMP(a_capture_settled, aclk, aresetn, cmd.capture, !sts.need_step)
    `VRTS_ASSERT_NXT(a_capture_shows, aclk, aresetn, cmd.capture, m_tvalid && s_tready)

endmodule

// File: rtl/video_raster_timing_sync_status.sv
// Raster timing and sync status.
// s_ channel: each transaction carries advance_ns, the nanoseconds elapsed
// since the previous one; zero only reads the status.
// m_ channel: one transaction per input with line, field, sync and frame status.
// APB port: eight configuration registers at byte addresses 0x00..0x1C; write
// only while no transaction is in flight.
// An accepted advance holds off the next one until its result is captured:
// the line counter steps once a cycle, one line per step, through a single
// subtract-and-compare, then the output register takes the result and raises
// m_tvalid; the capture waits while the output register is still full.
// A zero line time or a short advance needs no line step.
// Reset (aresetn low, synchronous) clears the line, time, field and frame
// counters and loads the register defaults.
// While the receiver stalls, the result holds in the output register and the
// next advance is still accepted and stepped; its result waits until the
// output register is free.
module video_raster_timing_sync_status
    import vrts_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [15:0] advance_ns
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [9:0] scan_line, [10] odd_field, [11] display_active, [12] hsync_off,
    // [13] vsync_off, [14] frame_started, [46:15] frames_seen, [47] zero
    output logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    cfg_t cfg;
    cmd_t cmd;
    sts_t sts;

    vrts_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    vrts_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    vrts_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .cmd        (cmd),
        .advance_ns (s_tdata[ADV_W-1:0]),
        .sts        (sts),
        .out_data   (m_tdata)
    );

endmodule

// File: test/tb_top.sv
module tb_top;
    import vrts_pkg::*;

    typedef struct {
        logic [SCAN_W-1:0]  scan_line;
        logic               odd_field;
        logic               display_active;
        logic               hsync_off;
        logic               vsync_off;
        logic               frame_started;
        logic [FRAME_W-1:0] frames_seen;
    } sync_status_t;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    class raster_scoreboard;
        cfg_t              regs;
        logic [9:0]        line_cnt;
        int unsigned       ns_in_line;
        logic              field;
        logic [31:0]       frame_cnt;
        sync_status_t      pending_status[$];
        int                fails;

        function new();
            regs.frame_lines      = RST_FRAME_LINES;
            regs.line_time        = RST_LINE_TIME;
            regs.interlace_on     = RST_INTERLACE;
            regs.vsync_line_count = RST_VSYNC_LINES;
            regs.hsync_width      = RST_HSYNC_WIDTH;
            regs.front_porch      = RST_FRONT_PORCH;
            regs.back_porch       = RST_BACK_PORCH;
            regs.retrace_end      = RST_RETRACE_END;
            line_cnt   = '0;
            ns_in_line = 0;
            field      = 1'b0;
            frame_cnt  = '0;
            fails      = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                REG_FRAME_LINES:  regs.frame_lines      = val[10:0];
                REG_LINE_TIME:    regs.line_time        = val[15:0];
                REG_INTERLACE_ON: regs.interlace_on     = val[0];
                REG_VSYNC_LINES:  regs.vsync_line_count = val[3:0];
                REG_HSYNC_WIDTH:  regs.hsync_width      = val[15:0];
                REG_FRONT_PORCH:  regs.front_porch      = val[15:0];
                REG_BACK_PORCH:   regs.back_porch       = val[15:0];
                REG_RETRACE_END:  regs.retrace_end      = val[9:0];
                default: ;
            endcase
        endfunction

        // Step the raster by one advance and queue the status it should report.
        function void note_advance(logic [15:0] adv);
            sync_status_t st;
            logic [9:0]   nxt;
            int unsigned  limit;
            st.frame_started = 1'b0;
            if (regs.line_time != 0) begin
                ns_in_line += adv;
                while (ns_in_line >= regs.line_time) begin
                    nxt = line_cnt + 10'd1;
                    ns_in_line -= regs.line_time;
                    if (nxt == 0 || {1'b0, nxt} >= regs.frame_lines) begin
                        nxt = '0;
                        if (regs.interlace_on)
                            field = ~field;
                    end
                    line_cnt = nxt;
                    if (line_cnt == regs.retrace_end) begin
                        frame_cnt += 1;
                        st.frame_started = 1'b1;
                    end
                end
            end
            st.vsync_off = (line_cnt >= regs.vsync_line_count);
            if (line_cnt[0] == field) begin
                st.hsync_off      = (ns_in_line > regs.hsync_width);
                st.display_active = st.vsync_off && (ns_in_line > regs.front_porch);
            end else begin
                limit = (regs.line_time > regs.back_porch) ?
                        regs.line_time - regs.back_porch : 0;
                st.hsync_off      = 1'b1;
                st.display_active = st.vsync_off && (ns_in_line < limit);
            end
            st.scan_line   = line_cnt;
            st.odd_field   = field;
            st.frames_seen = frame_cnt;
            pending_status.push_back(st);
        endfunction

        function void check_status(logic [OUT_TDATA_W-1:0] data);
            sync_status_t exp_st;
            if (pending_status.size() == 0) begin
                $error("status transaction with none expected: %h", data);
                fails++;
                return;
            end
            exp_st = pending_status.pop_front();
            if (data[9:0] !== exp_st.scan_line) begin
                $error("scan_line: expected %0d, got %0d", exp_st.scan_line, data[9:0]);
                fails++;
            end
            if (data[10] !== exp_st.odd_field) begin
                $error("odd_field: expected %0d, got %0d", exp_st.odd_field, data[10]);
                fails++;
            end
            if (data[11] !== exp_st.display_active) begin
                $error("display_active: expected %0d, got %0d",
                       exp_st.display_active, data[11]);
                fails++;
            end
            if (data[12] !== exp_st.hsync_off) begin
                $error("hsync_off: expected %0d, got %0d", exp_st.hsync_off, data[12]);
                fails++;
            end
            if (data[13] !== exp_st.vsync_off) begin
                $error("vsync_off: expected %0d, got %0d", exp_st.vsync_off, data[13]);
                fails++;
            end
            if (data[14] !== exp_st.frame_started) begin
                $error("frame_started: expected %0d, got %0d",
                       exp_st.frame_started, data[14]);
                fails++;
            end
            if (data[46:15] !== exp_st.frames_seen) begin
                $error("frames_seen: expected %0d, got %0d",
                       exp_st.frames_seen, data[46:15]);
                fails++;
            end
        endfunction
    endclass

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   psel     = 1'b0;
    logic                   penable  = 1'b0;
    logic                   pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr    = '0;
    logic [APB_DATA_W-1:0]  pwdata   = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    raster_scoreboard sb = new();
    idle_mode_t       idle_mode = IDLE_NONE;

    video_raster_timing_sync_status u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        if (idle_mode == IDLE_RECEIVER)
            m_tready <= ($urandom_range(99) >= 83);
        else if (idle_mode == IDLE_BOTH)
            m_tready <= ($urandom_range(99) >= 34);
        else
            m_tready <= 1'b1;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_status(m_tdata);
    end

    initial begin
        #8000000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic int sender_gap();
        int pct;
        int n;
        pct = (idle_mode == IDLE_SENDER) ? 83 : (idle_mode == IDLE_BOTH) ? 34 : 0;
        n = 0;
        while ($urandom_range(99) < pct)
            n++;
        return n;
    endfunction

    task automatic send_advance(logic [15:0] adv, int gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= adv;
        do @(posedge aclk); while (!s_tready);
        sb.note_advance(adv);
    endtask

    // Leaves psel high so that writes may follow back to back.
    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.set_reg(idx, val);
    endtask

    task automatic load_settings(cfg_t c);
        reg_write(REG_FRAME_LINES,  32'(c.frame_lines));
        reg_write(REG_LINE_TIME,    32'(c.line_time));
        reg_write(REG_INTERLACE_ON, 32'(c.interlace_on));
        reg_write(REG_VSYNC_LINES,  32'(c.vsync_line_count));
        reg_write(REG_HSYNC_WIDTH,  32'(c.hsync_width));
        reg_write(REG_FRONT_PORCH,  32'(c.front_porch));
        reg_write(REG_BACK_PORCH,   32'(c.back_porch));
        reg_write(REG_RETRACE_END,  32'(c.retrace_end));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending_status.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    initial begin
        logic [15:0] corner_adv[16];
        cfg_t        plan[8];
        int          plan_items[8];
        int          plan_adv_max[8];
        int          count;
        logic [15:0] adv;

        corner_adv = '{16'd0, 16'hFFFF, 16'd0, 16'd1, 16'd31999, 16'd1, 16'd32000,
                       16'd4740, 16'd4741, 16'h5555, 16'hAAAA, 16'h8000, 16'h7FFF,
                       16'd64000, 16'd3999, 16'd0};

        // total, line ns, interlace, vsync lines, hsync, front, back, retrace end
        plan[0] = '{11'd8,    16'd1000,  1'b1, 4'd2,  16'd300,   16'd100,   16'd200,   10'd3};
        // one line per frame, every width at its top
        plan[1] = '{11'd1,    16'hFFFF,  1'b0, 4'd15, 16'hFFFF,  16'hFFFF,  16'hFFFF,  10'd0};
        // total of zero wraps on every line
        plan[2] = '{11'd0,    16'd2000,  1'b1, 4'd1,  16'd500,   16'd1500,  16'd100,   10'd0};
        // total beyond the counter range
        plan[3] = '{11'd1024, 16'd7,     1'b1, 4'd0,  16'd0,     16'd0,     16'd0,     10'd1023};
        // frozen timing
        plan[4] = '{11'd20,   16'd0,     1'b0, 4'd3,  16'd10,    16'd5,     16'd2,     10'd6};
        // back porch longer than the line, retrace end never reached
        plan[5] = '{11'd12,   16'd3000,  1'b1, 4'd4,  16'd2900,  16'd3100,  16'd5000,  10'd20};
        plan[6] = '{11'd600,  16'd500,   1'b0, 4'd7,  16'd0,     16'd0,     16'd0,     10'd599};
        plan[6].hsync_width = 16'($urandom_range(0, 600));
        plan[6].front_porch = 16'($urandom_range(0, 600));
        plan[6].back_porch  = 16'($urandom_range(0, 600));
        plan[7] = '{RST_FRAME_LINES, RST_LINE_TIME, RST_INTERLACE, RST_VSYNC_LINES,
                    RST_HSYNC_WIDTH, RST_FRONT_PORCH, RST_BACK_PORCH, RST_RETRACE_END};
        plan_items   = '{200, 150, 100, 200, 60, 150, 200, 150};
        plan_adv_max = '{65535, 65535, 8000, 300, 65535, 20000, 65535, 65535};

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (corner_adv[i])
            send_advance(corner_adv[i], 0);
        drain();

        count = 0;
        foreach (plan[p]) begin
            load_settings(plan[p]);
            for (int i = 0; i < plan_items[p]; i++) begin
                idle_mode = idle_mode_t'((count / 40) % 4);
                count++;
                if ($urandom_range(9) == 0)
                    adv = '0;
                else
                    adv = 16'($urandom_range(0, plan_adv_max[p]));
                send_advance(adv, sender_gap());
            end
            drain();
        end

        idle_mode = IDLE_NONE;
        repeat (20) @(posedge aclk);
        if (sb.fails == 0 && sb.pending_status.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
